// File: hdl/bqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

    localparam logic [5:0] Q4_BLOCK_BYTES = 6'd18;
    localparam logic [5:0] Q8_BLOCK_BYTES = 6'd34;
    localparam logic       FMT_Q4_0       = 1'b0;
    localparam logic       FMT_Q8_0       = 1'b1;
    localparam logic [31:0] DEFAULT_NAN   = 32'hFFC0_0000;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [4:0]  element_index;
        logic        run_last;
        logic        block_last;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/bqd_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module bqd_mult
(
    input  wire logic [15:0] scale_half,
    input  wire logic [7:0]  q,
    output logic      [31:0] value_bits
);
    import bqd_pkg::*;

    logic        hs;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic        qneg;
    logic [7:0]  mag;
    logic        sign;
    logic [10:0] m;
    logic [17:0] prod;
    logic [4:0]  p;
    logic [8:0]  biased;
    logic [40:0] shifted;

    always_comb
    begin
        hs      = scale_half[15];
        ex      = scale_half[14:10];
        fr      = scale_half[9:0];
        qneg    = q[7];
        mag     = qneg ? (8'd0 - q) : q;
        sign    = hs ^ qneg;
        m       = (ex != 5'd0) ? {1'b1, fr} : {1'b0, fr};
        prod    = {7'd0, m} * {10'd0, mag};
        p       = 5'd0;
        for (int i = 0; i < 18; i++)
        begin
            if (prod[i])
            begin
                p = 5'(i);
            end
        end
        biased  = 9'(({4'd0, p} + ((ex != 5'd0) ? {4'd0, ex} : 9'd1)) + 9'd102);
        shifted = {23'd0, prod} << (5'd23 - p);
        if (ex == 5'h1F)
        begin
            if (fr != 10'd0)
            begin
                value_bits = {hs, 8'hFF, 1'b1, fr[8:0], 13'd0};
            end
            else if (mag == 8'd0)
            begin
                value_bits = DEFAULT_NAN;
            end
            else
            begin
                value_bits = {sign, 8'hFF, 23'd0};
            end
        end
        else if (mag == 8'd0 || (ex == 5'd0 && fr == 10'd0))
        begin
            value_bits = {sign, 31'd0};
        end
        else
        begin
            value_bits = {sign, biased[7:0], shifted[22:0]};
        end
    end

endmodule

`default_nettype wire

// File: hdl/block_quant_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Block dequantizer for 32-element Q4_0 / Q8_0 blocks.
// Input stream s_axis: one raw byte per transaction, two scale bytes
// (little-endian half float) first, then the payload bytes of the block.
// Output stream m_axis: one float32 element per transaction with its index,
// tlast on the last element produced by a byte and tuser set on index 31.
// A Q8_0 payload byte gives one result, a Q4_0 byte gives two (low nibble
// element, then high nibble element), so a Q4_0 byte holds off the next
// byte until its second element is taken; the single output register sets this.
// The result is registered and is valid in the cycle after the input transaction.
// The input is taken whenever the output register is empty or being
// emptied by its last pending element; a stalled receiver holds all.
// Writing cfg_wdata with cfg_we loads the format and restarts block alignment
// at byte 0; the scale is kept. Reset clears the position, scale and format to zero.
module block_quant_dequantizer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // value_bits, element_index, 3 zero bits
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // block_last
);
    import bqd_pkg::*;

    logic        fmt_reg;
    logic [5:0]  pos_reg, pos_next, pos_cur, len;
    logic [15:0] scale_reg, scale_next;
    logic        valid_reg, pend_reg;
    logic [15:0] oscale_reg;
    logic [7:0]  q_reg, q2_reg;
    logic [4:0]  idx_reg;
    logic        blast_reg;
    logic        in_acc, out_acc, emits, is_q8;
    logic [7:0]  q_sel;
    logic [31:0] value;

    assign len    = fmt_reg ? Q8_BLOCK_BYTES : Q4_BLOCK_BYTES;
    assign pos_cur = (pos_reg >= len) ? 6'd0 : pos_reg;
    assign is_q8  = (fmt_reg == FMT_Q8_0);
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !valid_reg || (out_acc && !pend_reg);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign emits  = (pos_cur >= 6'd2);

    always_comb
    begin
        scale_next = scale_reg;
        if (pos_cur == 6'd0)
        begin
            scale_next[7:0] = s_axis_tdata;
        end
        else if (pos_cur == 6'd1)
        begin
            scale_next[15:8] = s_axis_tdata;
        end
        pos_next = ((pos_cur + 6'd1) >= len) ? 6'd0 : pos_cur + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_Q4_0;
            pos_reg   <= 6'd0;
            scale_reg <= 16'd0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_wdata;
                pos_reg <= 6'd0;
            end
            else if (in_acc)
            begin
                pos_reg <= pos_next;
            end
            if (in_acc)
            begin
                scale_reg <= scale_next;
            end
            if (in_acc)
            begin
                valid_reg <= emits;
                pend_reg  <= emits && !is_q8;
            end
            else if (out_acc)
            begin
                valid_reg <= pend_reg;
                pend_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            oscale_reg <= scale_reg;
            idx_reg    <= 5'(pos_cur - 6'd2);
            blast_reg  <= is_q8 ? (pos_cur == 6'd33) : 1'b0;
            if (is_q8)
            begin
                q_reg <= s_axis_tdata;
            end
            else
            begin
                q_reg  <= {4'd0, s_axis_tdata[3:0]} - 8'd8;
                q2_reg <= {4'd0, s_axis_tdata[7:4]} - 8'd8;
            end
        end
        else if (out_acc && pend_reg)
        begin
            q_reg     <= q2_reg;
            idx_reg   <= idx_reg + 5'd16;
            blast_reg <= (idx_reg == 5'd15);
        end
    end

    assign q_sel = q_reg;

    bqd_mult u_mult
    (
        .scale_half (oscale_reg),
        .q          (q_sel),
        .value_bits (value)
    );

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'd0, idx_reg, value};
    assign m_axis_tlast  = !pend_reg;
    assign m_axis_tuser  = blast_reg;

    a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg) else $error("pending without valid");
    a_no_take_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !s_axis_tready) else $error("input taken while pending");
    a_block_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && blast_reg) |-> (idx_reg == 5'd31)) else $error("block_last index");

endmodule

`default_nettype wire
